### hw/rtl/mi3_pkg.sv
// Types, constants and division step for the 3x3 matrix inverse core.
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int unsigned NumEnt   = 9;
  localparam int unsigned DivSteps = 4;
  localparam int unsigned DivStg   = 32 / DivSteps;
  localparam int unsigned NumStg   = 6 + DivStg;

  localparam logic [31:0] SatMax = 32'h7fff_ffff;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_in_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic               singular;
  } mat_out_t;

  typedef struct packed {
    logic [49:0] rem;
    logic [31:0] nbits;
    logic [31:0] quo;
    logic        neg;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NumEnt-1:0] ln;
    logic  [49:0]       dmag;
    logic               sing;
  } div_stage_t;

  function automatic lane_t div_step(lane_t l, logic [49:0] d);
    lane_t       o;
    logic [50:0] r;
    o = l;
    for (int s = 0; s < DivSteps; s++) begin
      r       = {o.rem, o.nbits[31]};
      o.nbits = {o.nbits[30:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r     = r - {1'b0, d};
        o.quo = {o.quo[30:0], 1'b1};
      end else begin
        o.quo = {o.quo[30:0], 1'b0};
      end
      o.rem = r[49:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] sat_out(lane_t l, logic sing);
    logic [31:0] v;
    if (sing) begin
      v = '0;
    end else if (!l.neg) begin
      v = (l.ovf || l.quo[31]) ? SatMax : l.quo;
    end else begin
      v = (l.ovf || (l.quo > SatMin)) ? SatMin : (~l.quo + 32'd1);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mi3_if.sv
// Valid/ready channels carrying a matrix in and an inverse out.
`timescale 1ns / 1ps
`default_nettype none
interface mi3_in_if;
  import mi3_pkg::*;
  logic    valid;
  logic    ready;
  mat_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic     valid;
  logic     ready;
  mat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/matrix_inverse_3x3_core.sv
// 3x3 matrix inverse: Q8.8 matrix in, Q16.16 saturated inverse out.
// The core is a 14-stage pipeline: products, cofactors, determinant terms,
// determinant sum, magnitudes, eight restoring-division stages of four quotient
// bits each, and the output register. It takes one matrix per cycle unless the
// output stalls, and inverses leave in the order of their inputs; per-stage valid
// bits let a stall at the output fill empty stages before the input stops.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_core
  import mi3_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);

  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   rdy;

  assign rdy[NumStg] = out_o.ready;
  for (genvar k = 0; k < NumStg; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_i.ready = rdy[0];

  // stage 0: products
  logic signed [31:0] pa_q [NumEnt];
  logic signed [31:0] pb_q [NumEnt];
  logic signed [15:0] a0_q [3];
  logic signed [15:0] a0b_q [3];
  mat_in_t m;
  assign m = in_i.data;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pa_q[0] <= m.m11 * m.m22; pb_q[0] <= m.m12 * m.m21;
      pa_q[1] <= m.m12 * m.m20; pb_q[1] <= m.m10 * m.m22;
      pa_q[2] <= m.m10 * m.m21; pb_q[2] <= m.m11 * m.m20;
      pa_q[3] <= m.m02 * m.m21; pb_q[3] <= m.m01 * m.m22;
      pa_q[4] <= m.m00 * m.m22; pb_q[4] <= m.m02 * m.m20;
      pa_q[5] <= m.m01 * m.m20; pb_q[5] <= m.m00 * m.m21;
      pa_q[6] <= m.m01 * m.m12; pb_q[6] <= m.m02 * m.m11;
      pa_q[7] <= m.m02 * m.m10; pb_q[7] <= m.m00 * m.m12;
      pa_q[8] <= m.m00 * m.m11; pb_q[8] <= m.m01 * m.m10;
      a0_q[0] <= m.m00; a0_q[1] <= m.m01; a0_q[2] <= m.m02;
    end
  end

  // stage 1: cofactors
  logic signed [32:0] cof1_q [NumEnt];
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < NumEnt; i++) begin
        cof1_q[i] <= 33'(pa_q[i]) - 33'(pb_q[i]);
      end
      a0b_q <= a0_q;
    end
  end

  // stage 2: determinant terms
  logic signed [32:0] cof2_q [NumEnt];
  logic signed [48:0] dp_q [3];
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      cof2_q <= cof1_q;
      for (int j = 0; j < 3; j++) begin
        dp_q[j] <= 49'(a0b_q[j]) * 49'(cof1_q[j]);
      end
    end
  end

  // stage 3: determinant
  logic signed [32:0] cof3_q [NumEnt];
  logic signed [50:0] det_q;
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      cof3_q <= cof2_q;
      det_q  <= 51'(dp_q[0]) + 51'(dp_q[1]) + 51'(dp_q[2]);
    end
  end

  // stage 4: magnitudes, overflow check, division setup
  div_stage_t div_q [DivStg+1];
  div_stage_t div_d0;
  logic [50:0] dabs;
  logic [32:0] cabs;

  always_comb begin
    dabs          = det_q[50] ? (~det_q + 51'd1) : det_q;
    div_d0.dmag   = dabs[49:0];
    div_d0.sing   = (det_q == '0);
    cabs          = '0;
    for (int k = 0; k < NumEnt; k++) begin
      // result (i, j) takes cofactor (j, i)
      cabs = cof3_q[(k % 3) * 3 + (k / 3)][32] ? (~cof3_q[(k % 3) * 3 + (k / 3)] + 33'd1)
                                               : cof3_q[(k % 3) * 3 + (k / 3)];
      div_d0.ln[k].rem   = {26'd0, cabs[31:8]};
      div_d0.ln[k].nbits = {cabs[7:0], 24'd0};
      div_d0.ln[k].quo   = '0;
      div_d0.ln[k].neg   = cof3_q[(k % 3) * 3 + (k / 3)][32] ^ det_q[50];
      div_d0.ln[k].ovf   = {26'd0, cabs[31:8]} >= dabs[49:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) div_q[0] <= div_d0;
  end

  // stages 5 .. 12: restoring division
  for (genvar s = 0; s < DivStg; s++) begin : g_div
    div_stage_t nxt;
    always_comb begin
      nxt = div_q[s];
      for (int k = 0; k < NumEnt; k++) begin
        nxt.ln[k] = div_step(div_q[s].ln[k], div_q[s].dmag);
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[5+s]) div_q[s+1] <= nxt;
    end
  end

  // stage 13: sign and saturation
  mat_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (rdy[NumStg-1]) begin
      out_q.r00      <= sat_out(div_q[DivStg].ln[0], div_q[DivStg].sing);
      out_q.r01      <= sat_out(div_q[DivStg].ln[1], div_q[DivStg].sing);
      out_q.r02      <= sat_out(div_q[DivStg].ln[2], div_q[DivStg].sing);
      out_q.r10      <= sat_out(div_q[DivStg].ln[3], div_q[DivStg].sing);
      out_q.r11      <= sat_out(div_q[DivStg].ln[4], div_q[DivStg].sing);
      out_q.r12      <= sat_out(div_q[DivStg].ln[5], div_q[DivStg].sing);
      out_q.r20      <= sat_out(div_q[DivStg].ln[6], div_q[DivStg].sing);
      out_q.r21      <= sat_out(div_q[DivStg].ln[7], div_q[DivStg].sing);
      out_q.r22      <= sat_out(div_q[DivStg].ln[8], div_q[DivStg].sing);
      out_q.singular <= div_q[DivStg].sing;
    end
  end

  assign out_o.valid = v_q[NumStg-1];
  assign out_o.data  = out_q;

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.singular) |->
      (out_o.data.r00 == '0 && out_o.data.r11 == '0 && out_o.data.r22 == '0 &&
       out_o.data.r01 == '0 && out_o.data.r12 == '0 && out_o.data.r20 == '0))
    else $error("singular result carries nonzero entries");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready && $countones(v_q) == NumStg))
    else $error("input stalled with a free pipeline stage");

endmodule
`default_nettype wire

### dv/matrix_inverse_3x3_core_test.sv
// Testbench for the 3x3 matrix inverse core: directed table, random matrices, checked by predictor.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3_core_test;
  import mi3_pkg::*;

  localparam int unsigned NumRandom = 1830;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  mi3_in_if  mat_ch ();
  mi3_out_if inv_ch ();

  matrix_inverse_3x3_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (mat_ch.sink),
    .out_o  (inv_ch.source)
  );

  typedef struct {
    mat_in_t  m;
    logic     known;
    mat_out_t r;
  } row_t;

  mat_out_t inverse_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          hold_long;
  bit          done_send;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic logic [31:0] clamp_q16(longint v);
    if (v > longint'(32'sh7fff_ffff)) return 32'h7fff_ffff;
    if (v < -longint'(64'sh8000_0000)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic mat_out_t invert(mat_in_t m);
    longint a[3][3];
    longint c[3][3];
    longint det;
    longint q;
    logic [31:0] v[9];
    mat_out_t o;
    int r0, r1, c0, c1;
    a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
    a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
    a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r0 = (i == 0) ? 1 : 0;
        r1 = (i == 2) ? 1 : 2;
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        c[i][j] = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
        if ((i + j) % 2 == 1) c[i][j] = -c[i][j];
      end
    end
    det = a[0][0] * c[0][0] + a[0][1] * c[0][1] + a[0][2] * c[0][2];
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q = (c[j][i] * 64'sd16777216) / det;
        v[i * 3 + j] = clamp_q16(q);
      end
    end
    o.r00 = v[0]; o.r01 = v[1]; o.r02 = v[2];
    o.r10 = v[3]; o.r11 = v[4]; o.r12 = v[5];
    o.r20 = v[6]; o.r21 = v[7]; o.r22 = v[8];
    return o;
  endfunction

  function automatic mat_in_t mat(int e0, int e1, int e2, int e3, int e4,
                                  int e5, int e6, int e7, int e8);
    mat_in_t m;
    m = {e0[15:0], e1[15:0], e2[15:0], e3[15:0], e4[15:0],
         e5[15:0], e6[15:0], e7[15:0], e8[15:0]};
    return m;
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mat_in_t rand_mat();
    mat_in_t m;
    int k;
    m = '0;
    for (int i = 0; i < 9; i++) m[i*16 +: 16] = rand_entry();
    k = $urandom_range(0, 9);
    if (k == 0) begin
      m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02;
    end else if (k == 1) begin
      m.m02 = 16'sd0; m.m12 = 16'sd0; m.m22 = 16'sd0;
    end else if (k == 2) begin
      m = '0;
      m.m00 = 16'($urandom_range(1, 600));
      m.m11 = 16'($urandom_range(1, 600));
      m.m22 = 16'($urandom_range(1, 600));
    end
    return m;
  endfunction

  row_t dir_rows[$];

  task automatic send(mat_in_t m);
    mat_ch.valid <= 1'b1;
    mat_ch.data  <= m;
    do @(posedge clk_i); while (!mat_ch.ready);
    inverse_q.push_back(invert(m));
  endtask

  task automatic gap();
    mat_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic check(mat_out_t exp_r, mat_out_t got);
    if (exp_r !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h actual %h", exp_r, got);
    end
  endtask

  initial begin
    mat_out_t z;
    mat_out_t id;
    row_t row;
    int burst;
    mismatches = 0;
    done_send  = 1'b0;
    hold_long  = 1'b0;
    rst_ni       = 1'b0;
    mat_ch.valid = 1'b0;
    mat_ch.data  = '0;
    z = '0;
    z.singular = 1'b1;
    id = '0;
    id.r00 = 32'h10000; id.r11 = 32'h10000; id.r22 = 32'h10000;
    dir_rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
    dir_rows.push_back('{mat(256, 0, 0, 0, 256, 0, 0, 0, 256), 1'b1, id});
    dir_rows.push_back('{mat(1, 2, 3, 1, 2, 3, 7, 8, 9), 1'b1, z});
    dir_rows.push_back('{mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, z});
    dir_rows.push_back('{mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767), 1'b0, z});
    dir_rows.push_back('{mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, z});
    dir_rows.push_back('{mat(-1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, z});
    dir_rows.push_back('{mat(-32768, -32768, -32768, -32768, 32767, 32767,
                             -32768, 32767, -32768), 1'b0, z});
    dir_rows.push_back('{mat(32767, -1, 0, 1, 32767, -1, 0, 1, 32767), 1'b0, z});
    dir_rows.push_back('{mat(0, 256, 0, 0, 0, 256, 256, 0, 0), 1'b0, z});
    dir_rows.push_back('{mat(512, 128, -64, 3, -700, 90, 11, 5, 300), 1'b0, z});
    dir_rows.push_back('{mat(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1, z});
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.known && row.r !== invert(row.m)) begin
        mismatches++;
        $display("table row %0d disagrees with predictor", i);
      end
      send(row.m);
      if ($urandom_range(0, 1)) gap();
    end
    hold_long = 1'b1;
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < NumRandom; b++, n++) send(rand_mat());
      if ($urandom_range(0, 3) != 0) gap();
    end
    mat_ch.valid <= 1'b0;
    done_send = 1'b1;
  end

  initial begin
    int hold;
    inv_ch.ready = 1'b1;
    wait (rst_ni);
    wait (hold_long);
    inv_ch.ready <= 1'b0;
    repeat (60) @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, 9);
      if (hold < 4) inv_ch.ready <= 1'b1;
      else if (hold < 8) inv_ch.ready <= $urandom_range(0, 1);
      else inv_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && inv_ch.valid && inv_ch.ready) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h", inv_ch.data);
      end else begin
        check(inverse_q.pop_front(), inv_ch.data);
      end
    end
  end

  initial begin
    cycles = 0;
    fork
      begin
        wait (done_send);
        while (inverse_q.size() != 0) @(posedge clk_i);
        repeat (40) @(posedge clk_i);
      end
      forever begin
        @(posedge clk_i);
        cycles++;
        if (cycles >= CycleLimit) break;
      end
    join_any
    if (cycles >= CycleLimit || inverse_q.size() != 0) begin
      $display("Some tests failed");
    end else if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_if.sv
hw/rtl/matrix_inverse_3x3_core.sv
dv/matrix_inverse_3x3_core_test.sv
